>>> design/ncb_pkg.sv
// ----------------------------------------------------------------------------
// ncb_pkg
// Shared widths, register indexes and the work-item type for the
// NCHW to channel-blocked reorder.
// ----------------------------------------------------------------------------
package ncb_pkg;

  localparam int BLOCK_SIZE_DEFAULT = 16;
  // Lane field covers the largest supported block (64 lanes).
  localparam int LANE_W = 6;

  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 32;
  localparam int CC_W       = 13;
  localparam int SS_W       = 21;
  localparam int CH_POS_W   = 12;
  localparam int SP_POS_W   = 20;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 21;

  localparam logic [CC_W-1:0] CC_MIN   = 13'd1;
  localparam logic [CC_W-1:0] CC_MAX   = 13'd4096;
  localparam logic [CC_W-1:0] CC_RESET = 13'd16;
  localparam logic [SS_W-1:0] SS_MIN   = 21'd1;
  localparam logic [SS_W-1:0] SS_MAX   = 21'd1048576;
  localparam logic [SS_W-1:0] SS_RESET = 21'd1;

  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPATIAL_SIZE  = 1'd1;

  typedef struct packed {
    logic [INDEX_W-1:0] dest_index;
    logic [VALUE_W-1:0] value;
    logic [LANE_W-1:0]  lane;
    logic               last_chan;
    logic               image_done;
  } job_t;

endpackage

>>> design/ncb_ifs.sv
// ----------------------------------------------------------------------------
// ncb_ifs
// Stream and configuration channel interfaces (valid/ready).
// ----------------------------------------------------------------------------
interface ncb_in_if;
  logic                       valid;
  logic                       ready;
  logic [ncb_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ncb_out_if;
  logic                        valid;
  logic                        ready;
  logic [ncb_pkg::INDEX_W-1:0] dest_index;
  logic [ncb_pkg::VALUE_W-1:0] value_out;
  logic                        is_padding;
  logic                        last_of_run;
  logic                        image_done;

  modport source (output valid, output dest_index, output value_out, output is_padding,
                  output last_of_run, output image_done, input ready);
  modport sink   (input valid, input dest_index, input value_out, input is_padding,
                  input last_of_run, input image_done, output ready);
endinterface

interface ncb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ncb_pkg::CFG_ADDR_W-1:0] index;
  logic [ncb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/ncb_emit.sv
// ----------------------------------------------------------------------------
// ncb_emit
// Job register plus output register; expands the padding lanes of the
// last channel one word per cycle while dst is ready.
// ----------------------------------------------------------------------------
module ncb_emit #(
  parameter int BLOCK_SIZE = ncb_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  ncb_pkg::job_t job_in,
  input  logic          job_in_valid,
  output logic          job_in_ready,
  ncb_out_if.source     dst
);

  localparam logic [ncb_pkg::LANE_W-1:0] LANE_END = ncb_pkg::LANE_W'(BLOCK_SIZE - 1);

  ncb_pkg::job_t job;
  logic          job_valid;

  logic [ncb_pkg::INDEX_W-1:0] dest_index;
  logic [ncb_pkg::VALUE_W-1:0] value_out;
  logic                        is_padding;
  logic                        last_of_run;
  logic                        image_done;
  logic [ncb_pkg::LANE_W-1:0]  lane;
  logic                        out_valid;

  logic out_free;
  logic job_take;
  logic pad_step;

  assign out_free     = !out_valid || dst.ready;
  assign pad_step     = out_free && out_valid && !last_of_run;
  assign job_take     = out_free && (!out_valid || last_of_run) && job_valid;
  assign job_in_ready = !job_valid || job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (job_in_valid && job_in_ready) begin
      job_valid <= 1'b1;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_in_valid && job_in_ready) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pad_step || job_take;
    end
  end

  always_ff @(posedge clk) begin
    if (pad_step) begin
      dest_index  <= dest_index + 32'd1;
      value_out   <= '0;
      is_padding  <= 1'b1;
      lane        <= lane + 1'b1;
      last_of_run <= (lane + 1'b1) == LANE_END;
    end else if (job_take) begin
      dest_index  <= job.dest_index;
      value_out   <= job.value;
      is_padding  <= 1'b0;
      lane        <= job.lane;
      last_of_run <= !(job.last_chan && job.lane != LANE_END);
      image_done  <= job.image_done;
    end
  end

  assign dst.valid       = out_valid;
  assign dst.dest_index  = dest_index;
  assign dst.value_out   = value_out;
  assign dst.is_padding  = is_padding;
  assign dst.last_of_run = last_of_run;
  assign dst.image_done  = image_done;

endmodule

>>> design/nchw_to_blocked_channels.sv
// ----------------------------------------------------------------------------
// nchw_to_blocked_channels
// Reorders one image's words from channel-major order into the
// channel-blocked layout and pads a partial final block with zeros.
//
//   channel  dir  word contents
//   src      in   value: source element, channel-major then spatial
//   dst      out  dest_index, value_out, is_padding, last_of_run, image_done
//   cfg      in   index 0: channel_count, index 1: spatial_size
//
// One source word per cycle while dst is ready and the word causes no padding;
// a last-channel word is then padded with zero words up to the block end, one
// lane per cycle while dst is ready. Words pass through a job register, then
// the output register, which absorb stalls. Synchronous reset clears the
// position counters and loads channel_count = 16, spatial_size = 1.
// ----------------------------------------------------------------------------
module nchw_to_blocked_channels #(
  parameter int BLOCK_SIZE = ncb_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  ncb_in_if.sink     src,
  ncb_out_if.source  dst,
  ncb_cfg_if.sink    cfg
);

  localparam logic [ncb_pkg::LANE_W-1:0] LANE_END = ncb_pkg::LANE_W'(BLOCK_SIZE - 1);
  localparam logic [ncb_pkg::INDEX_W-1:0] ROW_STEP = ncb_pkg::INDEX_W'(BLOCK_SIZE);

  logic [ncb_pkg::CC_W-1:0] channel_count;
  logic [ncb_pkg::SS_W-1:0] spatial_size;

  logic [ncb_pkg::CH_POS_W-1:0] channel_pos;
  logic [ncb_pkg::SP_POS_W-1:0] spatial_pos;
  logic [ncb_pkg::INDEX_W-1:0]  block_base;
  logic [ncb_pkg::INDEX_W-1:0]  row_off;
  logic [ncb_pkg::LANE_W-1:0]   lane;

  logic [ncb_pkg::CC_W-1:0] cc_sat;
  logic [ncb_pkg::SS_W-1:0] ss_sat;
  logic                     last_chan;
  logic                     last_pos;
  logic                     done;
  logic                     in_fire;
  logic                     job_ready;
  ncb_pkg::job_t            job;

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= ncb_pkg::CC_RESET;
      spatial_size  <= ncb_pkg::SS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ncb_pkg::REG_CHANNEL_COUNT: channel_count <= cfg.data[ncb_pkg::CC_W-1:0];
        ncb_pkg::REG_SPATIAL_SIZE:  spatial_size  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cc_sat = channel_count;
    if (channel_count < ncb_pkg::CC_MIN) cc_sat = ncb_pkg::CC_MIN;
    if (channel_count > ncb_pkg::CC_MAX) cc_sat = ncb_pkg::CC_MAX;
    ss_sat = spatial_size;
    if (spatial_size < ncb_pkg::SS_MIN) ss_sat = ncb_pkg::SS_MIN;
    if (spatial_size > ncb_pkg::SS_MAX) ss_sat = ncb_pkg::SS_MAX;
  end

  assign last_chan = {1'b0, channel_pos} >= (cc_sat - 13'd1);
  assign last_pos  = {1'b0, spatial_pos} >= (ss_sat - 21'd1);
  assign done      = last_chan && last_pos;
  assign in_fire   = src.valid && job_ready;
  assign src.ready = job_ready;

  always_comb begin
    job.dest_index = block_base + row_off + {{(ncb_pkg::INDEX_W-ncb_pkg::LANE_W){1'b0}}, lane};
    job.value      = src.value;
    job.lane       = lane;
    job.last_chan  = last_chan;
    job.image_done = done;
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_pos <= '0;
      spatial_pos <= '0;
      block_base  <= '0;
      row_off     <= '0;
      lane        <= '0;
    end else if (in_fire) begin
      priority if (done) begin
        channel_pos <= '0;
        spatial_pos <= '0;
        block_base  <= '0;
        row_off     <= '0;
        lane        <= '0;
      end else if (last_pos) begin
        spatial_pos <= '0;
        row_off     <= '0;
        channel_pos <= channel_pos + 12'd1;
        if (lane == LANE_END) begin
          lane       <= '0;
          block_base <= block_base
                        + ROW_STEP * {{(ncb_pkg::INDEX_W-ncb_pkg::SS_W){1'b0}}, ss_sat};
        end else begin
          lane <= lane + 1'b1;
        end
      end else begin
        spatial_pos <= spatial_pos + 20'd1;
        row_off     <= row_off + ROW_STEP;
      end
    end
  end

  ncb_emit #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .job_in       (job),
    .job_in_valid (src.valid),
    .job_in_ready (job_ready),
    .dst          (dst)
  );

endmodule
